[rtl/ctt_pkg.sv]
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, token kinds, grammar positions and error codes of the
// configuration text tokenizer and checker.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 128;

    // token kinds
    localparam logic [3:0] K_LPAREN   = 4'd0;
    localparam logic [3:0] K_RPAREN   = 4'd1;
    localparam logic [3:0] K_LBRACKET = 4'd2;
    localparam logic [3:0] K_RBRACKET = 4'd3;
    localparam logic [3:0] K_LBRACE   = 4'd4;
    localparam logic [3:0] K_RBRACE   = 4'd5;
    localparam logic [3:0] K_COMMA    = 4'd6;
    localparam logic [3:0] K_PLUS     = 4'd7;
    localparam logic [3:0] K_MINUS    = 4'd8;
    localparam logic [3:0] K_DOT      = 4'd9;
    localparam logic [3:0] K_ASSIGN   = 4'd10;
    localparam logic [3:0] K_IDENT    = 4'd11;
    localparam logic [3:0] K_NUMBER   = 4'd12;
    localparam logic [3:0] K_INVALID  = 4'd13;
    localparam logic [3:0] K_EOF      = 4'd14;

    // verdicts
    localparam logic [1:0] V_PARSING  = 2'd0;
    localparam logic [1:0] V_ACCEPT   = 2'd1;
    localparam logic [1:0] V_ERROR    = 2'd2;

    // error codes
    localparam logic [3:0] E_NONE      = 4'd0;
    localparam logic [3:0] E_LBRACKET  = 4'd1;
    localparam logic [3:0] E_IDENT     = 4'd2;
    localparam logic [3:0] E_RBRACKET  = 4'd3;
    localparam logic [3:0] E_ASSIGN    = 4'd4;
    localparam logic [3:0] E_VALUE     = 4'd5;
    localparam logic [3:0] E_ARGSEP    = 4'd6;
    localparam logic [3:0] E_HEADER    = 4'd7;
    localparam logic [3:0] E_TOO_LONG  = 4'd8;
    localparam logic [3:0] E_BAD_CHAR  = 4'd9;

    // lexer modes
    localparam logic [1:0] LM_IDLE   = 2'd0;
    localparam logic [1:0] LM_NUMBER = 2'd1;
    localparam logic [1:0] LM_IDENT  = 2'd2;

    // grammar positions
    localparam logic [4:0] P_HDR_FIRST = 5'd0;
    localparam logic [4:0] P_HDR_IDENT = 5'd1;
    localparam logic [4:0] P_HDR_CLOSE = 5'd2;
    localparam logic [4:0] P_BODY      = 5'd3;
    localparam logic [4:0] P_EQ        = 5'd4;
    localparam logic [4:0] P_VALUE     = 5'd5;
    localparam logic [4:0] P_NUM_DONE  = 5'd6;
    localparam logic [4:0] P_FRAC      = 5'd7;
    localparam logic [4:0] P_BR_IDENT  = 5'd8;
    localparam logic [4:0] P_BR_ARGS   = 5'd9;
    localparam logic [4:0] P_ARG       = 5'd10;
    localparam logic [4:0] P_ARG_NUM   = 5'd11;
    localparam logic [4:0] P_ARG_FRAC  = 5'd12;
    localparam logic [4:0] P_BR_DONE   = 5'd13;
    localparam logic [4:0] P_BR_OPEN   = 5'd14;

    // lexed event from front to back
    typedef struct packed {
        logic       flush_vld;   // pending token ends here
        logic [3:0] flush_kind;
        logic [7:0] flush_len;
        logic       tok_vld;     // punctuation, invalid or eof token
        logic [3:0] tok_kind;
        logic       too_long;    // flush is an overlong token
        logic       is_eof;
        logic       nl;          // raise the line counter after tokens
    } ctt_evt_t;

    // one result item
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  token_length;
        logic [15:0] line_number;
        logic [1:0]  verdict;
        logic [3:0]  error_code;
        logic        last;
    } ctt_res_t;

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        k = 5'h1f;
        case (c)
            8'h28: k = {1'b0, K_LPAREN};
            8'h29: k = {1'b0, K_RPAREN};
            8'h5b: k = {1'b0, K_LBRACKET};
            8'h5d: k = {1'b0, K_RBRACKET};
            8'h7b: k = {1'b0, K_LBRACE};
            8'h7d: k = {1'b0, K_RBRACE};
            8'h2c: k = {1'b0, K_COMMA};
            8'h2b: k = {1'b0, K_PLUS};
            8'h2d: k = {1'b0, K_MINUS};
            8'h2e: k = {1'b0, K_DOT};
            8'h3d: k = {1'b0, K_ASSIGN};
            default: k = 5'h1f;
        endcase
        return k;
    endfunction

endpackage

[rtl/ctt_lexer.sv]
// ----------------------------------------------------------------------------
// ctt_lexer
// Front part: takes characters, groups digit runs and identifiers, and
// issues one lexed event per character that matters to the grammar.
// ----------------------------------------------------------------------------
module ctt_lexer #(
    parameter int MAX_TOKEN_LEN = ctt_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              end_of_file,
    output logic              evt_valid,
    input  logic              evt_ready,
    output ctt_pkg::ctt_evt_t evt
);

    logic [1:0] mode_reg, mode_next;
    logic [7:0] plen_reg, plen_next;
    logic       drop_reg, drop_next;     // discarding until end of file
    logic       digit, alpha, ws, nl, cont;
    logic [4:0] pk;
    ctt_pkg::ctt_evt_t e;
    logic       emit;

    assign in_ready = evt_ready;

    // classify the character and decide what to emit
    always_comb
    begin
        digit = (char_code >= 8'h30) && (char_code <= 8'h39);
        alpha = ((char_code >= 8'h61) && (char_code <= 8'h7a)) ||
                ((char_code >= 8'h41) && (char_code <= 8'h5a)) || (char_code == 8'h5f);
        nl    = (char_code == 8'h0a);
        ws    = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0d));
        pk    = ctt_pkg::punct_kind(char_code);
        cont  = ((mode_reg == ctt_pkg::LM_NUMBER) && digit) ||
                ((mode_reg == ctt_pkg::LM_IDENT) && (digit || alpha));
        e = '0;
        mode_next = mode_reg;
        plen_next = plen_reg;
        drop_next = drop_reg;
        emit = 1'b0;
        e.flush_kind = (mode_reg == ctt_pkg::LM_NUMBER) ? ctt_pkg::K_NUMBER : ctt_pkg::K_IDENT;
        e.flush_len  = plen_reg;
        if (end_of_file)
        begin
            e.flush_vld = (mode_reg != ctt_pkg::LM_IDLE) && !drop_next;
            e.tok_vld   = 1'b1;
            e.tok_kind  = ctt_pkg::K_EOF;
            e.is_eof    = 1'b1;
            emit = 1'b1;
            mode_next = ctt_pkg::LM_IDLE;
            plen_next = '0;
            drop_next = 1'b0;
        end
        else if (drop_next)
        begin
            mode_next = ctt_pkg::LM_IDLE;
            plen_next = '0;
        end
        else if (cont)
        begin
            if (plen_reg >= 8'(MAX_TOKEN_LEN))
            begin
                e.flush_vld = 1'b1;
                e.flush_len = 8'(MAX_TOKEN_LEN);
                e.too_long  = 1'b1;
                emit = 1'b1;
                mode_next = ctt_pkg::LM_IDLE;
                plen_next = '0;
                drop_next = 1'b1;
            end
            else
            begin
                plen_next = plen_reg + 8'd1;
            end
        end
        else
        begin
            e.flush_vld = (mode_reg != ctt_pkg::LM_IDLE);
            mode_next = ctt_pkg::LM_IDLE;
            plen_next = '0;
            if (nl)
            begin
                e.nl = 1'b1;
            end
            else if (ws)
            begin
                e.nl = 1'b0;
            end
            else if (digit)
            begin
                mode_next = ctt_pkg::LM_NUMBER;
                plen_next = 8'd1;
            end
            else if (alpha)
            begin
                mode_next = ctt_pkg::LM_IDENT;
                plen_next = 8'd1;
            end
            else
            begin
                e.tok_vld  = 1'b1;
                e.tok_kind = pk[4] ? ctt_pkg::K_INVALID : pk[3:0];
            end
            emit = e.flush_vld || e.tok_vld || e.nl;
        end
    end

    assign evt_valid = in_valid && emit;
    assign evt       = e;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ctt_pkg::LM_IDLE;
            plen_reg <= '0;
            drop_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            mode_reg <= mode_next;
            plen_reg <= plen_next;
            drop_reg <= drop_next;
        end
    end

endmodule

[rtl/ctt_queue.sv]
// ----------------------------------------------------------------------------
// ctt_queue
// Two-entry event queue between the lexer and the grammar checker.
// ----------------------------------------------------------------------------
module ctt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  ctt_pkg::ctt_evt_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output ctt_pkg::ctt_evt_t rd_data
);

    ctt_pkg::ctt_evt_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !wr)
        else $error("write into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !rd)
        else $error("read from empty queue");

endmodule

[rtl/ctt_checker.sv]
// ----------------------------------------------------------------------------
// ctt_checker
// Back part: runs the grammar on lexed events, keeps line count and error,
// and sends up to two result items per event through an output register.
// ----------------------------------------------------------------------------
module ctt_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_ready,
    input  ctt_pkg::ctt_evt_t evt,
    output logic              res_valid,
    input  logic              res_ready,
    output ctt_pkg::ctt_res_t res
);

    logic [4:0]  pos_reg, pos_next, pos_mid;
    logic [3:0]  err_reg, err_next, err_mid;
    logic [15:0] line_reg, line_next;
    logic        phase_reg, phase_next;      // flush result already sent
    ctt_pkg::ctt_res_t out_reg;
    logic        ovld_reg;
    logic        load, two, cur_flush, done, err_set;
    logic [3:0]  kind;
    logic [7:0]  len;
    logic [1:0]  verdict;
    logic        emits;

    // grammar transition for one token
    function automatic logic [10:0] gstep(input logic [4:0] p, input logic [3:0] k);
        logic [4:0] np;
        logic [3:0] e;
        logic [1:0] v;
        np = p;
        e  = ctt_pkg::E_NONE;
        v  = ctt_pkg::V_PARSING;
        unique case (p)
            ctt_pkg::P_HDR_FIRST:
                if (k == ctt_pkg::K_LBRACKET) np = ctt_pkg::P_HDR_IDENT;
                else e = ctt_pkg::E_LBRACKET;
            ctt_pkg::P_HDR_IDENT:
                if (k == ctt_pkg::K_IDENT) np = ctt_pkg::P_HDR_CLOSE;
                else e = ctt_pkg::E_IDENT;
            ctt_pkg::P_HDR_CLOSE:
                if (k == ctt_pkg::K_RBRACKET) np = ctt_pkg::P_BODY;
                else e = ctt_pkg::E_RBRACKET;
            ctt_pkg::P_EQ:
                if (k == ctt_pkg::K_ASSIGN) np = ctt_pkg::P_VALUE;
                else e = ctt_pkg::E_ASSIGN;
            ctt_pkg::P_VALUE:
                if (k == ctt_pkg::K_NUMBER) np = ctt_pkg::P_NUM_DONE;
                else if (k == ctt_pkg::K_LBRACE) np = ctt_pkg::P_BR_IDENT;
                else e = ctt_pkg::E_VALUE;
            ctt_pkg::P_BR_IDENT:
                if (k == ctt_pkg::K_IDENT) np = ctt_pkg::P_BR_ARGS;
                else e = ctt_pkg::E_IDENT;
            ctt_pkg::P_ARG:
                if (k == ctt_pkg::K_NUMBER) np = ctt_pkg::P_ARG_NUM;
                else if (k == ctt_pkg::K_IDENT) np = ctt_pkg::P_BR_ARGS;
                else e = ctt_pkg::E_VALUE;
            ctt_pkg::P_BR_OPEN:
                if (k == ctt_pkg::K_LBRACE) np = ctt_pkg::P_BR_IDENT;
                else e = ctt_pkg::E_VALUE;
            ctt_pkg::P_BR_ARGS, ctt_pkg::P_ARG_NUM, ctt_pkg::P_ARG_FRAC:
                if ((p == ctt_pkg::P_ARG_NUM) && (k == ctt_pkg::K_DOT))
                    np = ctt_pkg::P_ARG_FRAC;
                else if ((p == ctt_pkg::P_ARG_FRAC) && (k == ctt_pkg::K_NUMBER))
                    np = ctt_pkg::P_BR_ARGS;
                else if (k == ctt_pkg::K_COMMA) np = ctt_pkg::P_ARG;
                else if (k == ctt_pkg::K_RBRACE) np = ctt_pkg::P_BR_DONE;
                else e = ctt_pkg::E_ARGSEP;
            default:
                // body, number done, fraction, brace done
                if ((p == ctt_pkg::P_NUM_DONE) && (k == ctt_pkg::K_DOT))
                    np = ctt_pkg::P_FRAC;
                else if ((p == ctt_pkg::P_FRAC) && (k == ctt_pkg::K_NUMBER))
                    np = ctt_pkg::P_BODY;
                else if ((p == ctt_pkg::P_BR_DONE) && (k == ctt_pkg::K_COMMA))
                    np = ctt_pkg::P_BR_OPEN;
                else if (k == ctt_pkg::K_IDENT) np = ctt_pkg::P_EQ;
                else if (k == ctt_pkg::K_LBRACKET) np = ctt_pkg::P_HDR_IDENT;
                else if (k == ctt_pkg::K_EOF) v = ctt_pkg::V_ACCEPT;
                else e = ctt_pkg::E_HEADER;
        endcase
        if (e != ctt_pkg::E_NONE) v = ctt_pkg::V_ERROR;
        return {np, e, v};
    endfunction

    // pick the token of this phase and step the grammar
    // once an error is latched only the eof token gives a result
    always_comb
    begin
        err_set   = (err_reg != ctt_pkg::E_NONE);
        cur_flush = evt.flush_vld && !phase_reg && !err_set;
        two       = evt.flush_vld && evt.tok_vld;
        kind      = cur_flush ? evt.flush_kind : evt.tok_kind;
        len       = cur_flush ? evt.flush_len : 8'd1;
        pos_mid   = pos_reg;
        err_mid   = err_reg;
        verdict   = ctt_pkg::V_PARSING;
        emits     = cur_flush || (evt.tok_vld && (evt.is_eof || !err_set));
        if (cur_flush && evt.too_long)
        begin
            err_mid = ctt_pkg::E_TOO_LONG;
            verdict = ctt_pkg::V_ERROR;
        end
        else if (!cur_flush && evt.is_eof)
        begin
            len = '0;
            if (err_set)
                verdict = ctt_pkg::V_ERROR;
            else
                {pos_mid, err_mid, verdict} = gstep(pos_reg, kind);
        end
        else if (emits && !cur_flush && (kind == ctt_pkg::K_INVALID))
        begin
            err_mid = ctt_pkg::E_BAD_CHAR;
            verdict = ctt_pkg::V_ERROR;
        end
        else if (emits)
        begin
            {pos_mid, err_mid, verdict} = gstep(pos_reg, kind);
        end
        // an error on the flush token drops the rest unless at eof
        done = !(cur_flush && two) ||
               ((err_mid != ctt_pkg::E_NONE) && !evt.is_eof);
    end

    assign load      = evt_valid && (!ovld_reg || res_ready);
    assign evt_ready = load && done;

    // next state of the grammar side
    always_comb
    begin
        pos_next   = pos_reg;
        err_next   = err_reg;
        line_next  = line_reg;
        phase_next = phase_reg;
        if (load)
        begin
            pos_next   = pos_mid;
            err_next   = err_mid;
            phase_next = !done;
            if (done)
            begin
                if (evt.nl && (line_reg != 16'hffff) && (err_mid == ctt_pkg::E_NONE))
                    line_next = line_reg + 16'd1;
                if (evt.is_eof)
                begin
                    pos_next  = ctt_pkg::P_HDR_FIRST;
                    err_next  = ctt_pkg::E_NONE;
                    line_next = 16'd1;
                end
            end
        end
    end

    // grammar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= ctt_pkg::P_HDR_FIRST;
            err_reg   <= ctt_pkg::E_NONE;
            line_reg  <= 16'd1;
            phase_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            line_reg  <= line_next;
            phase_reg <= phase_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (load)
        begin
            ovld_reg <= emits;
        end
        else if (res_ready)
        begin
            ovld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.token_kind   <= kind;
            out_reg.token_length <= len;
            out_reg.line_number  <= line_reg;
            out_reg.verdict      <= verdict;
            out_reg.error_code   <= err_mid;
            out_reg.last         <= done;
        end
    end

    assign res_valid = ovld_reg;
    assign res       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.verdict == ctt_pkg::V_ERROR)) |-> (res.error_code != ctt_pkg::E_NONE))
        else $error("error verdict without code");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.token_kind == ctt_pkg::K_EOF)) |-> res.last)
        else $error("eof result not last");
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> evt_valid)
        else $error("second phase without event");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> ($stable(res) && res_valid))
        else $error("result changed while stalled");

endmodule

[rtl/config_text_tokenizer_checker.sv]
// ----------------------------------------------------------------------------
// config_text_tokenizer_checker
// Tokenizer and grammar checker for sectioned configuration text.
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tuser / tlast
// s_axis   in   [7:0] char_code                    tuser: end_of_file
// m_axis   out  kind, length, line, verdict, error tlast: last
//
// one character is taken per cycle; the lexer state loop sets that rate
// a character that ends a token and is itself a token, or end of file
// after a pending token, gives up to two result items
// reset clears lexer, grammar and error and sets the line count to 1; no clearing pass
// a stall on m_axis fills the two-entry event queue, then holds s_axis
// ----------------------------------------------------------------------------
module config_text_tokenizer_checker #(
    parameter int MAX_TOKEN_LEN = ctt_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [11:4] token_length,
                                        // [27:12] line_number, [29:28] verdict,
                                        // [33:30] error_code, [39:34] zero
    output logic        m_axis_tlast    // last
);

    ctt_pkg::ctt_evt_t lx_evt, q_evt;
    logic lx_valid, lx_ready, q_valid, q_ready;
    ctt_pkg::ctt_res_t res;

    ctt_lexer #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_lexer (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .char_code(s_axis_tdata), .end_of_file(s_axis_tuser),
        .evt_valid(lx_valid), .evt_ready(lx_ready), .evt(lx_evt)
    );

    ctt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(lx_valid), .wr_ready(lx_ready), .wr_data(lx_evt),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_evt)
    );

    ctt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .evt_valid(q_valid), .evt_ready(q_ready), .evt(q_evt),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {6'd0, res.error_code, res.verdict, res.line_number,
                           res.token_length, res.token_kind};
    assign m_axis_tlast = res.last;

endmodule
